### design/lpr_pkg.sv
`timescale 1ns / 1ps

package lpr_pkg;

  localparam int COORD_BITS = 6;
  localparam int REG_BITS   = COORD_BITS + 1;
  localparam int ERR_BITS   = COORD_BITS + 3;
  localparam int COLOUR_BITS = 32;
  localparam int CMD_DEPTH  = 4;
  localparam int INDEX_BITS = 2;

  localparam logic [INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [REG_BITS-1:0] TILE_SIZE = REG_BITS'(1 << COORD_BITS);

  typedef struct packed {
    logic [COORD_BITS-1:0]  start_x;
    logic [COORD_BITS-1:0]  start_y;
    logic [COORD_BITS-1:0]  end_x;
    logic [COORD_BITS-1:0]  end_y;
    logic [COLOUR_BITS-1:0] colour;
  } line_cmd_t;

  typedef struct packed {
    logic [COORD_BITS-1:0]  pixel_x;
    logic [COORD_BITS-1:0]  pixel_y;
    logic [COLOUR_BITS-1:0] pixel_colour;
    logic                   visible;
    logic                   last;
  } pixel_t;

  // classified line as it waits between front and walker
  typedef struct packed {
    logic [COORD_BITS-1:0]      start_x;
    logic [COORD_BITS-1:0]      start_y;
    logic [COORD_BITS-1:0]      end_x;
    logic [COORD_BITS-1:0]      end_y;
    logic [COORD_BITS-1:0]      span_x;
    logic [COORD_BITS-1:0]      span_y;
    logic                       x_down;
    logic                       y_down;
    logic signed [ERR_BITS-1:0] error_term;
    logic [COLOUR_BITS-1:0]     colour;
  } line_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } walk_state_t;

endpackage

### design/lpr_front.sv
`timescale 1ns / 1ps

module lpr_front (
  input  lpr_pkg::line_cmd_t   cmd,
  output lpr_pkg::line_entry_t entry
);

  logic [lpr_pkg::COORD_BITS-1:0] span_x;
  logic [lpr_pkg::COORD_BITS-1:0] span_y;
  logic                           x_down;
  logic                           y_down;

  always_comb begin
    x_down = !(cmd.start_x < cmd.end_x);
    y_down = !(cmd.start_y < cmd.end_y);
    span_x = x_down ? (cmd.start_x - cmd.end_x) : (cmd.end_x - cmd.start_x);
    span_y = y_down ? (cmd.start_y - cmd.end_y) : (cmd.end_y - cmd.start_y);
  end

  always_comb begin
    entry.start_x    = cmd.start_x;
    entry.start_y    = cmd.start_y;
    entry.end_x      = cmd.end_x;
    entry.end_y      = cmd.end_y;
    entry.span_x     = span_x;
    entry.span_y     = span_y;
    entry.x_down     = x_down;
    entry.y_down     = y_down;
    // initial error |dx| - |dy|
    entry.error_term = $signed({{(lpr_pkg::ERR_BITS - lpr_pkg::COORD_BITS){1'b0}}, span_x})
                     - $signed({{(lpr_pkg::ERR_BITS - lpr_pkg::COORD_BITS){1'b0}}, span_y});
    entry.colour     = cmd.colour;
  end

endmodule

### design/lpr_cmd_queue.sv
`timescale 1ns / 1ps

module lpr_cmd_queue #(
  parameter int DEPTH = lpr_pkg::CMD_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr,
  input  lpr_pkg::line_entry_t wr_entry,
  input  logic                 rd,
  output lpr_pkg::line_entry_t rd_entry,
  output lpr_pkg::queue_status_t status
);

  localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_BITS = $clog2(DEPTH + 1);
  localparam logic [PTR_BITS-1:0]   LAST_SLOT = PTR_BITS'(DEPTH - 1);
  localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(DEPTH);

  lpr_pkg::line_entry_t mem [DEPTH];

  logic [PTR_BITS-1:0]   wr_ptr;
  logic [PTR_BITS-1:0]   rd_ptr;
  logic [COUNT_BITS-1:0] count;
  logic                  do_wr;
  logic                  do_rd;

  assign status.empty = (count == '0);
  assign status.full  = (count == FULL_COUNT);
  assign do_wr = wr && !status.full;
  assign do_rd = rd && !status.empty;
  assign rd_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### design/lpr_walker.sv
`timescale 1ns / 1ps

module lpr_walker (
  input  logic                            clk,
  input  logic                            rst,
  input  lpr_pkg::queue_status_t          q_status,
  input  lpr_pkg::line_entry_t            q_entry,
  output logic                            q_pop,
  input  logic [lpr_pkg::REG_BITS-1:0]    image_width,
  input  logic [lpr_pkg::REG_BITS-1:0]    image_height,
  output lpr_pkg::pixel_t                 pixel,
  output logic                            empty,
  input  logic                            pop
);

  localparam int CB = lpr_pkg::COORD_BITS;
  localparam int EB = lpr_pkg::ERR_BITS;

  lpr_pkg::walk_state_t state;
  lpr_pkg::walk_state_t state_next;

  logic [CB-1:0]          cursor_x;
  logic [CB-1:0]          cursor_y;
  logic [CB-1:0]          target_x;
  logic [CB-1:0]          target_y;
  logic [CB-1:0]          span_x;
  logic [CB-1:0]          span_y;
  logic                   x_down;
  logic                   y_down;
  logic signed [EB-1:0]   error_term;
  logic [CB-1:0]          count;
  logic [lpr_pkg::COLOUR_BITS-1:0] colour;
  logic                   out_valid;

  logic                   out_space;
  logic                   load;
  logic                   emit;
  logic                   final_px;
  logic signed [EB:0]     e2;
  logic signed [EB:0]     sx_w;
  logic signed [EB:0]     sy_w;
  logic signed [EB-1:0]   sx_e;
  logic signed [EB-1:0]   sy_e;
  logic                   step_x;
  logic                   step_y;

  assign out_space = !out_valid || pop;
  assign empty     = !out_valid;

  always_comb begin
    final_px = ((cursor_x == target_x) && (cursor_y == target_y)) || (count == '1);
    e2   = $signed({error_term, 1'b0});
    sx_w = $signed({{(EB + 1 - CB){1'b0}}, span_x});
    sy_w = $signed({{(EB + 1 - CB){1'b0}}, span_y});
    sx_e = $signed({{(EB - CB){1'b0}}, span_x});
    sy_e = $signed({{(EB - CB){1'b0}}, span_y});
    // y test uses the doubled error from before the x step
    step_x = (e2 >= -sy_w) && (cursor_x != target_x);
    step_y = (e2 <= sx_w) && (cursor_y != target_y);
  end

  always_comb begin
    state_next = state;
    case (state)
      lpr_pkg::ST_IDLE: begin
        if (!q_status.empty) begin
          state_next = lpr_pkg::ST_WALK;
        end
      end
      lpr_pkg::ST_WALK: begin
        if (out_space && final_px) begin
          state_next = lpr_pkg::ST_IDLE;
        end
      end
      default: state_next = lpr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    load = 1'b0;
    emit = 1'b0;
    case (state)
      lpr_pkg::ST_IDLE: load = !q_status.empty;
      lpr_pkg::ST_WALK: emit = out_space;
      default: begin
        load = 1'b0;
        emit = 1'b0;
      end
    endcase
  end

  assign q_pop = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lpr_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x   <= '0;
      cursor_y   <= '0;
      target_x   <= '0;
      target_y   <= '0;
      span_x     <= '0;
      span_y     <= '0;
      x_down     <= 1'b0;
      y_down     <= 1'b0;
      error_term <= '0;
      count      <= '0;
    end else if (load) begin
      cursor_x   <= q_entry.start_x;
      cursor_y   <= q_entry.start_y;
      target_x   <= q_entry.end_x;
      target_y   <= q_entry.end_y;
      span_x     <= q_entry.span_x;
      span_y     <= q_entry.span_y;
      x_down     <= q_entry.x_down;
      y_down     <= q_entry.y_down;
      error_term <= q_entry.error_term;
      count      <= '0;
    end else if (emit && !final_px) begin
      if (step_x) begin
        cursor_x <= x_down ? cursor_x - 1'b1 : cursor_x + 1'b1;
      end
      if (step_y) begin
        cursor_y <= y_down ? cursor_y - 1'b1 : cursor_y + 1'b1;
      end
      error_term <= error_term - (step_x ? sy_e : '0) + (step_y ? sx_e : '0);
      count      <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      colour <= q_entry.colour;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pixel.pixel_x      <= cursor_x;
      pixel.pixel_y      <= cursor_y;
      pixel.pixel_colour <= colour;
      pixel.visible      <= ({1'b0, cursor_x} < image_width) &&
                            ({1'b0, cursor_y} < image_height);
      pixel.last         <= final_px;
    end
  end

endmodule

### design/line_pixel_rasterizer.sv
`timescale 1ns / 1ps

// bresenham line rasterizer for a 64 by 64 tile, all octants
// command channel: a line (start point, end point, colour) is taken at a
//   rising edge with push high and full low; a four-entry command queue
//   sits between the classifying front and the pixel walker
// pixel channel: while empty is low the oldest pixel sits on pixel; it is
//   taken at a rising edge with pop high; the last pixel of a line has last set
// config: wr_en writes wr_data into image_width (index 0) or image_height
//   (index 1); other indexes are dropped; write only while the block is idle
// throughput: a line of n = max(|dx|,|dy|)+1 pixels (1 to 64) is walked at
//   one pixel per cycle while the output register has room, after the walker
//   loads it from the queue; the walker's single cursor/error step sets this
// first pixel: the command is queued, loaded by the walker, then registered
// reset: rst empties the queue, idles the walker, empties the output
//   register, and sets width and height to 64
// stall: with pop low the output register holds its pixel and the walker
//   waits; commands keep being taken until the queue fills

module line_pixel_rasterizer #(
  parameter int CMD_DEPTH = lpr_pkg::CMD_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  // command side
  input  logic                              push,
  output logic                              full,
  input  lpr_pkg::line_cmd_t                cmd,
  // pixel side
  output logic                              empty,
  input  logic                              pop,
  output lpr_pkg::pixel_t                   pixel,
  // config write port
  input  logic                              wr_en,
  input  logic [lpr_pkg::INDEX_BITS-1:0]    wr_index,
  input  logic [lpr_pkg::REG_BITS-1:0]      wr_data
);

  logic [lpr_pkg::REG_BITS-1:0] image_width;
  logic [lpr_pkg::REG_BITS-1:0] image_height;

  lpr_pkg::line_entry_t   front_entry;
  lpr_pkg::line_entry_t   q_entry;
  lpr_pkg::queue_status_t q_status;
  logic                   q_pop;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= lpr_pkg::TILE_SIZE;
      image_height <= lpr_pkg::TILE_SIZE;
    end else if (wr_en) begin
      case (wr_index)
        lpr_pkg::REG_IMAGE_WIDTH:  image_width  <= wr_data;
        lpr_pkg::REG_IMAGE_HEIGHT: image_height <= wr_data;
        default: ;
      endcase
    end
  end

  // front: spans, step directions and initial error
  lpr_front u_front (
    .cmd   (cmd),
    .entry (front_entry)
  );

  assign full = q_status.full;

  // decouples command intake from the walk
  lpr_cmd_queue #(
    .DEPTH (CMD_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (push),
    .wr_entry (front_entry),
    .rd       (q_pop),
    .rd_entry (q_entry),
    .status   (q_status)
  );

  // back: one pixel per cycle into the output register while it has room
  lpr_walker u_walker (
    .clk          (clk),
    .rst          (rst),
    .q_status     (q_status),
    .q_entry      (q_entry),
    .q_pop        (q_pop),
    .image_width  (image_width),
    .image_height (image_height),
    .pixel        (pixel),
    .empty        (empty),
    .pop          (pop)
  );

endmodule

### design/lpr_checker.sv
`timescale 1ns / 1ps

module lpr_checker (
  input logic               clk,
  input logic               rst,
  input logic               push,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input lpr_pkg::pixel_t    pixel
);

  // reset leaves no pixel waiting
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("pixel shown right after reset");

  // a waiting pixel is held while not taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(pixel)))
    else $error("waiting pixel changed or vanished");

  // the queue fills only through an accepted command
  a_full_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(full) |-> $past(push))
    else $error("full rose without a push");

  // consecutive pixels of one line are neighbors and differ
  a_adjacent: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !pixel.last) ##1 !empty |->
      ((pixel.pixel_x == $past(pixel.pixel_x)) ||
       (pixel.pixel_x == $past(pixel.pixel_x) + 6'd1) ||
       (pixel.pixel_x == $past(pixel.pixel_x) - 6'd1)) &&
      ((pixel.pixel_y == $past(pixel.pixel_y)) ||
       (pixel.pixel_y == $past(pixel.pixel_y) + 6'd1) ||
       (pixel.pixel_y == $past(pixel.pixel_y) - 6'd1)) &&
      ((pixel.pixel_x != $past(pixel.pixel_x)) ||
       (pixel.pixel_y != $past(pixel.pixel_y))))
    else $error("pixel step is not to a neighbor");

endmodule

bind line_pixel_rasterizer lpr_checker u_lpr_checker (
  .clk   (clk),
  .rst   (rst),
  .push  (push),
  .full  (full),
  .empty (empty),
  .pop   (pop),
  .pixel (pixel)
);
